@@ sv/log2_latency_histogram_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef LOG2_LATENCY_HISTOGRAM_MACROS_SVH
`define LOG2_LATENCY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LLH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("llh check failed");

// Next-cycle implication, disabled while in reset.
`define LLH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("llh check failed");

`endif

@@ sv/llh_pkg.sv @@
package llh_pkg;

	localparam int NUM_BUCKETS  = 32;
	localparam int NUM_CHANNELS = 4;

	localparam int SAMPLE_W  = 32;
	localparam int CNT_W     = 32;
	localparam int SUM_W     = 64;
	localparam int EST_W     = 32;
	localparam int Q_W       = 10;
	localparam int CH_PORT_W = 2;
	localparam int MSB_W     = $clog2(SAMPLE_W);

	localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int BKT_IDX_W = $clog2(NUM_BUCKETS);
	localparam int ADDR_W    = CH_W + BKT_IDX_W;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	localparam int PERMILLE = 1000;
	localparam int SCALE_W  = $clog2(PERMILLE);
	localparam int TGT_W    = Q_W + CNT_W;
	localparam int RUN_W    = CNT_W + SCALE_W + BKT_IDX_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_Q  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_Q = 2'd1;
	localparam logic [Q_W-1:0] Q_LOW_RESET  = 10'd500;
	localparam logic [Q_W-1:0] Q_HIGH_RESET = 10'd990;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [CH_PORT_W-1:0] channel;
		logic [SAMPLE_W-1:0]  sample;
		logic [BKT_IDX_W-1:0] bucket;
	} llh_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} llh_q_status_t;

	typedef struct packed {
		logic [Q_W-1:0] q_low;
		logic [Q_W-1:0] q_high;
	} llh_cfg_t;

	// Estimate for a bucket: 1 for bucket 0, else 2^i, its smallest sample, capped at the top bit.
	function automatic logic [EST_W-1:0] llh_bound(input logic [BKT_IDX_W-1:0] idx);
		logic [EST_W-1:0] r;
		r = '0;
		if (idx == '0) begin
			r[0] = 1'b1;
		end else if (int'(idx) >= EST_W - 1) begin
			r[EST_W-1] = 1'b1;
		end else begin
			r = EST_W'(1) << idx;
		end
		return r;
	endfunction

endpackage

@@ sv/llh_ram.sv @@
module llh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/llh_front.sv @@
module llh_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          func,
	input  logic [llh_pkg::CH_PORT_W-1:0] channel,
	input  logic [llh_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          clearing,
	input  llh_pkg::llh_q_status_t        q_status,
	output logic                          busy,
	output logic                          push,
	output llh_pkg::llh_op_t              push_op
);
	import llh_pkg::*;

	logic                 valid_s1;
	logic                 func_s1;
	logic [CH_PORT_W-1:0] channel_s1;
	logic [SAMPLE_W-1:0]  sample_s1;
	logic [MSB_W-1:0]     msb;
	logic [BKT_IDX_W-1:0] bucket;
	logic                 accept;

	assign busy   = clearing | (valid_s1 & q_status.full);
	assign accept = start & ~busy;
	assign push   = valid_s1 & ~q_status.full;

	// floor(log2), with 0 and 1 both landing in bucket 0
	always_comb begin
		msb = '0;
		for (int i = 1; i < SAMPLE_W; i++) begin
			if (sample_s1[i]) begin
				msb = MSB_W'(i);
			end
		end
		if (int'(msb) > NUM_BUCKETS - 1) begin
			bucket = BKT_IDX_W'(NUM_BUCKETS - 1);
		end else begin
			bucket = BKT_IDX_W'(msb);
		end
	end

	always_comb begin
		push_op.func    = func_s1;
		push_op.channel = channel_s1;
		push_op.sample  = sample_s1;
		push_op.bucket  = bucket;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= func;
			channel_s1 <= channel;
			sample_s1  <= sample;
		end
	end

endmodule

@@ sv/llh_queue.sv @@
module llh_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  llh_pkg::llh_op_t       push_op,
	input  logic                   pop,
	output llh_pkg::llh_op_t       head,
	output llh_pkg::llh_q_status_t status
);
	import llh_pkg::*;

	llh_op_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (int'(p) == QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ sv/llh_back.sv @@
module llh_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  llh_pkg::llh_op_t             head,
	input  llh_pkg::llh_q_status_t       q_status,
	output logic                         pop,
	input  llh_pkg::llh_cfg_t            cfg,
	output logic                         clearing,
	output logic                         done,
	output logic [llh_pkg::CNT_W-1:0]    sample_total,
	output logic [llh_pkg::SUM_W-1:0]    latency_sum,
	output logic [llh_pkg::SAMPLE_W-1:0] latency_peak,
	output logic [llh_pkg::EST_W-1:0]    low_estimate,
	output logic [llh_pkg::EST_W-1:0]    high_estimate
);
	import llh_pkg::*;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_REC_WR   = 3'd2;
	localparam logic [2:0] ST_RPT_MUL  = 3'd3;
	localparam logic [2:0] ST_RPT_WALK = 3'd4;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   clr_idx_q;
	llh_op_t             op_q;

	logic [CNT_W-1:0]    cnt_q  [NUM_CHANNELS];
	logic [SUM_W-1:0]    sum_q  [NUM_CHANNELS];
	logic [SAMPLE_W-1:0] peak_q [NUM_CHANNELS];

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [CNT_W-1:0]    ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [CNT_W-1:0]    ram_rdata;

	logic [BKT_IDX_W:0]   rd_cnt_q;
	logic                 v_s1;
	logic [BKT_IDX_W-1:0] idx_s1;
	logic                 v_s2;
	logic [BKT_IDX_W-1:0] idx_s2;
	logic [RUN_W-1:0]     prod_s2;
	logic [RUN_W-1:0]     run_q;
	logic [TGT_W-1:0]     x_lo_q;
	logic [TGT_W-1:0]     x_hi_q;
	logic                 zero_q;
	logic                 found_lo_q;
	logic                 found_hi_q;
	logic [EST_W-1:0]     est_lo_q;
	logic [EST_W-1:0]     est_hi_q;

	logic                 done_q;
	logic [CNT_W-1:0]     total_o_q;
	logic [SUM_W-1:0]     sum_o_q;
	logic [SAMPLE_W-1:0]  peak_o_q;
	logic [EST_W-1:0]     lo_o_q;
	logic [EST_W-1:0]     hi_o_q;

	logic [CH_W-1:0]      head_ch;
	logic [CH_W-1:0]      op_ch;
	logic                 head_ok;
	logic                 op_ok;
	logic                 issue;
	logic [RUN_W-1:0]     run_nx;
	logic                 hit_lo;
	logic                 hit_hi;
	logic                 last_s2;
	logic [EST_W-1:0]     bound_s2;
	logic [SUM_W:0]       sum_nx;

	assign head_ch  = head.channel[CH_W-1:0];
	assign op_ch    = op_q.channel[CH_W-1:0];
	assign head_ok  = int'(head.channel) < NUM_CHANNELS;
	assign op_ok    = int'(op_q.channel) < NUM_CHANNELS;
	assign pop      = (state_q == ST_IDLE) & ~q_status.empty;
	assign clearing = (state_q == ST_CLEAR);
	assign issue    = (state_q == ST_RPT_WALK) &&
	                  (rd_cnt_q < (BKT_IDX_W + 1)'(NUM_BUCKETS));
	assign run_nx   = run_q + prod_s2;
	assign hit_lo   = !found_lo_q && (run_nx >= RUN_W'(x_lo_q));
	assign hit_hi   = !found_hi_q && (run_nx >= RUN_W'(x_hi_q));
	assign last_s2  = v_s2 && (idx_s2 == BKT_IDX_W'(NUM_BUCKETS - 1));
	assign bound_s2 = llh_bound(idx_s2);
	assign sum_nx   = {1'b0, sum_q[head_ch]} + (SUM_W + 1)'(head.sample);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {op_ch, op_q.bucket};
		ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
		ram_raddr = {op_ch, rd_cnt_q[BKT_IDX_W-1:0]};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_raddr = {head_ch, head.bucket};
			end
			ST_REC_WR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	llh_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MEM_DEPTH)
	) u_bucket_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_idx_q  <= '0;
			done_q     <= 1'b0;
			rd_cnt_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			found_lo_q <= 1'b0;
			found_hi_q <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				cnt_q[c]  <= '0;
				sum_q[c]  <= '0;
				peak_q[c] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == ADDR_W'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_status.empty) begin
						if (head.func == FUNC_REPORT) begin
							state_q <= ST_RPT_MUL;
						end else if (head_ok) begin
							if (cnt_q[head_ch] != '1) begin
								cnt_q[head_ch] <= cnt_q[head_ch] + 1'b1;
							end
							sum_q[head_ch] <= sum_nx[SUM_W] ? '1 : sum_nx[SUM_W-1:0];
							if (head.sample > peak_q[head_ch]) begin
								peak_q[head_ch] <= head.sample;
							end
							state_q <= ST_REC_WR;
						end
					end
				end
				ST_REC_WR: begin
					state_q <= ST_IDLE;
				end
				ST_RPT_MUL: begin
					rd_cnt_q   <= '0;
					v_s1       <= 1'b0;
					v_s2       <= 1'b0;
					found_lo_q <= 1'b0;
					found_hi_q <= 1'b0;
					state_q    <= ST_RPT_WALK;
				end
				ST_RPT_WALK: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					v_s1 <= issue;
					v_s2 <= v_s1;
					if (v_s2 && hit_lo) begin
						found_lo_q <= 1'b1;
					end
					if (v_s2 && hit_hi) begin
						found_hi_q <= 1'b1;
					end
					if (last_s2) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		if (state_q == ST_RPT_MUL) begin
			x_lo_q    <= TGT_W'(cfg.q_low) * TGT_W'(cnt_q[op_ch]);
			x_hi_q    <= TGT_W'(cfg.q_high) * TGT_W'(cnt_q[op_ch]);
			zero_q    <= !op_ok || (cnt_q[op_ch] == '0);
			run_q     <= '0;
			total_o_q <= op_ok ? cnt_q[op_ch] : '0;
			sum_o_q   <= op_ok ? sum_q[op_ch] : '0;
			peak_o_q  <= op_ok ? peak_q[op_ch] : '0;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[BKT_IDX_W-1:0];
		end
		if (v_s1) begin
			prod_s2 <= RUN_W'(ram_rdata) * RUN_W'(PERMILLE);
			idx_s2  <= idx_s1;
		end
		if (v_s2) begin
			run_q <= run_nx;
			if (hit_lo) begin
				est_lo_q <= bound_s2;
			end
			if (hit_hi) begin
				est_hi_q <= bound_s2;
			end
		end
		if (last_s2) begin
			lo_o_q <= zero_q ? '0 : (found_lo_q ? est_lo_q : bound_s2);
			hi_o_q <= zero_q ? '0 : (found_hi_q ? est_hi_q : bound_s2);
		end
	end

	assign done          = done_q;
	assign sample_total  = total_o_q;
	assign latency_sum   = sum_o_q;
	assign latency_peak  = peak_o_q;
	assign low_estimate  = lo_o_q;
	assign high_estimate = hi_o_q;

endmodule

@@ sv/log2_latency_histogram.sv @@
// Record: registered when taken, bucket classified from that register, then queued; then one
// read and one write of the bucket memory, and the next record waits until that write is done.
// Report: done pulses once the bucket walk through the memory's single read port has finished;
// one report at a time, records queue behind it.
// done lasts exactly one cycle and cannot be held off by the receiver.
// Reset: asynchronous, clears all counters; busy stays high as all 128 memory words are zeroed.
module log2_latency_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [llh_pkg::CH_PORT_W-1:0] channel,
	input  logic [llh_pkg::SAMPLE_W-1:0]  sample,
	output logic                          done,
	output logic [llh_pkg::CNT_W-1:0]     sample_total,
	output logic [llh_pkg::SUM_W-1:0]     latency_sum,
	output logic [llh_pkg::SAMPLE_W-1:0]  latency_peak,
	output logic [llh_pkg::EST_W-1:0]     low_estimate,
	output logic [llh_pkg::EST_W-1:0]     high_estimate,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [llh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [llh_pkg::Q_W-1:0]       cfg_data
);
	import llh_pkg::*;

	// Quantile registers; write only while idle (the block itself does not enforce it)
	logic [Q_W-1:0] q_low_q;
	logic [Q_W-1:0] q_high_q;
	llh_cfg_t       cfg;

	// Front to queue, queue to back
	logic          push;
	llh_op_t       push_op;
	logic          pop;
	llh_op_t       head;
	llh_q_status_t q_status;
	logic          clearing;

	// Writes are never refused: hold ready high
	assign cfg_ready  = 1'b1;
	assign cfg.q_low  = q_low_q;
	assign cfg.q_high = q_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_low_q  <= Q_LOW_RESET;
			q_high_q <= Q_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOW_Q:  q_low_q  <= cfg_data;
				CFG_HIGH_Q: q_high_q <= cfg_data;
				// drop writes to unknown registers
				default: begin
				end
			endcase
		end
	end

	// Front: take the request, work out its bucket, hand it on to the queue
	llh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.channel (channel),
		.sample  (sample),
		.clearing(clearing),
		.q_status(q_status),
		.busy    (busy),
		.push    (push),
		.push_op (push_op)
	);

	// Short queue so the front keeps accepting while the back walks buckets, until the queue fills
	llh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head   (head),
		.status (q_status)
	);

	// Back: update counters and buckets, or walk the buckets for a report
	llh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.cfg          (cfg),
		.clearing     (clearing),
		.done         (done),
		.sample_total (sample_total),
		.latency_sum  (latency_sum),
		.latency_peak (latency_peak),
		.low_estimate (low_estimate),
		.high_estimate(high_estimate)
	);

endmodule

@@ sv/llh_checker.sv @@
`include "log2_latency_histogram_macros.svh"

module llh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          func,
	input logic [llh_pkg::CH_PORT_W-1:0] channel,
	input logic [llh_pkg::SAMPLE_W-1:0]  sample,
	input logic                          done,
	input logic [llh_pkg::CNT_W-1:0]     sample_total,
	input logic [llh_pkg::SUM_W-1:0]     latency_sum,
	input logic [llh_pkg::SAMPLE_W-1:0]  latency_peak,
	input logic [llh_pkg::EST_W-1:0]     low_estimate,
	input logic [llh_pkg::EST_W-1:0]     high_estimate,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [llh_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [llh_pkg::Q_W-1:0]       cfg_data
);

	// A report walks every bucket, so two results never come back to back
	`LLH_ASSERT_NEXT(a_done_spaced, done, !done)
	// An empty channel reports nothing but zeros
	`LLH_ASSERT_NOW(a_empty_zero, done && sample_total == '0, latency_sum == '0 && latency_peak == '0 && low_estimate == '0 && high_estimate == '0)
	// A channel with samples reports a single bucket bound for each estimate
	`LLH_ASSERT_NOW(a_bound_onehot, done && sample_total != '0, $onehot(low_estimate) && $onehot(high_estimate))
	// The peak never exceeds the sum of the samples
	`LLH_ASSERT_NOW(a_peak_le_sum, done, {32'd0, latency_peak} <= latency_sum)

endmodule

bind log2_latency_histogram llh_checker u_llh_checker (.*);

@@ tb/log2_latency_histogram_checker.sv @@
`timescale 1ns / 1ps

module log2_latency_histogram_checker
	import llh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 func,
	input  logic [CH_PORT_W-1:0] channel,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 done,
	input  logic [CNT_W-1:0]     sample_total,
	input  logic [SUM_W-1:0]     latency_sum,
	input  logic [SAMPLE_W-1:0]  latency_peak,
	input  logic [EST_W-1:0]     low_estimate,
	input  logic [EST_W-1:0]     high_estimate,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,
	output int                   fail_count,
	output int                   reports_pending
);

	typedef struct packed {
		logic [CNT_W-1:0]    total;
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] peak;
		logic [EST_W-1:0]    low_est;
		logic [EST_W-1:0]    high_est;
	} channel_summary_t;

	logic [CNT_W-1:0]    bucket_tally [NUM_CHANNELS][NUM_BUCKETS];
	logic [CNT_W-1:0]    samples_seen [NUM_CHANNELS];
	logic [SUM_W-1:0]    latency_total [NUM_CHANNELS];
	logic [SAMPLE_W-1:0] latency_max [NUM_CHANNELS];
	logic [Q_W-1:0]      low_permille;
	logic [Q_W-1:0]      high_permille;
	channel_summary_t    summary_queue [$];
	int                  mismatches = 0;

	assign fail_count = mismatches;

	// Highest set bit, with 0 and 1 sharing the first bucket.
	function automatic int bucket_index(input logic [SAMPLE_W-1:0] s);
		int idx;
		idx = 0;
		for (int b = 1; b < SAMPLE_W; b++)
			if (s[b])
				idx = b;
		if (idx > NUM_BUCKETS - 1)
			idx = NUM_BUCKETS - 1;
		return idx;
	endfunction

	function automatic logic [EST_W-1:0] percentile_bound(input int ch, input logic [Q_W-1:0] q);
		logic [63:0] goal;
		logic [63:0] running;
		int          hit;
		if (samples_seen[ch] == '0)
			return '0;
		goal    = (64'(q) * 64'(samples_seen[ch]) + 64'd999) / 64'd1000;
		running = '0;
		hit     = NUM_BUCKETS - 1;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			running += 64'(bucket_tally[ch][i]);
			if (running >= goal) begin
				hit = i;
				break;
			end
		end
		if (hit == 0)
			return EST_W'(1);
		if (hit >= EST_W - 1)
			return {1'b1, {(EST_W-1){1'b0}}};
		return EST_W'(1) << hit;
	endfunction

	task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		channel_summary_t want;
		int               ch;
		int               b;
		if (!arst_n) begin
			low_permille  = Q_LOW_RESET;
			high_permille = Q_HIGH_RESET;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				samples_seen[c]  = '0;
				latency_total[c] = '0;
				latency_max[c]   = '0;
				for (int i = 0; i < NUM_BUCKETS; i++)
					bucket_tally[c][i] = '0;
			end
			summary_queue.delete();
			reports_pending <= 0;
		end else begin
			// compare a finished report against the oldest prediction
			if (done) begin
				if (summary_queue.size() == 0) begin
					mismatches++;
					$display("%0t: report result with nothing expected", $time);
				end else begin
					want = summary_queue.pop_front();
					flag_field("sample_total", 64'(want.total), 64'(sample_total));
					flag_field("latency_sum", want.sum, latency_sum);
					flag_field("latency_peak", 64'(want.peak), 64'(latency_peak));
					flag_field("low_estimate", 64'(want.low_est), 64'(low_estimate));
					flag_field("high_estimate", 64'(want.high_est), 64'(high_estimate));
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LOW_Q:  low_permille  = cfg_data;
					CFG_HIGH_Q: high_permille = cfg_data;
					default: ;
				endcase
			end

			if (start && !busy) begin
				ch = int'(channel);
				if (func == FUNC_RECORD) begin
					if (ch < NUM_CHANNELS) begin
						if (samples_seen[ch] != '1)
							samples_seen[ch]++;
						if (latency_total[ch] > ('1 - SUM_W'(sample)))
							latency_total[ch] = '1;
						else
							latency_total[ch] += SUM_W'(sample);
						if (sample > latency_max[ch])
							latency_max[ch] = sample;
						b = bucket_index(sample);
						if (bucket_tally[ch][b] != '1)
							bucket_tally[ch][b]++;
					end
				end else begin
					want = '0;
					if (ch < NUM_CHANNELS) begin
						want.total    = samples_seen[ch];
						want.sum      = latency_total[ch];
						want.peak     = latency_max[ch];
						want.low_est  = percentile_bound(ch, low_permille);
						want.high_est = percentile_bound(ch, high_permille);
					end
					summary_queue.push_back(want);
				end
			end
			reports_pending <= summary_queue.size();
		end
	end

endmodule

@@ tb/log2_latency_histogram_tb.sv @@
`timescale 1ns / 1ps

module log2_latency_histogram_tb;
	import llh_pkg::*;

	// Spare register indexes: writes there must leave both quantiles alone.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// A report walks every bucket and records may sit queued behind it, so
	// allow a comfortable margin before touching the registers or finishing.
	localparam int SETTLE_CYCLES = 64;
	// Worst case is roughly 1600 reports back to back, each walking every bucket,
	// plus sender gaps and the reset sweep; take that several times over.
	localparam int unsigned CYCLE_LIMIT = 600_000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 265;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 func;
	logic [CH_PORT_W-1:0] channel;
	logic [SAMPLE_W-1:0]  sample;
	logic                 done;
	logic [CNT_W-1:0]     sample_total;
	logic [SUM_W-1:0]     latency_sum;
	logic [SAMPLE_W-1:0]  latency_peak;
	logic [EST_W-1:0]     low_estimate;
	logic [EST_W-1:0]     high_estimate;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0]       cfg_data;

	int          fail_count;
	int          reports_pending;
	int unsigned cycle_count = 0;

	log2_latency_histogram dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.channel      (channel),
		.sample       (sample),
		.done         (done),
		.sample_total (sample_total),
		.latency_sum  (latency_sum),
		.latency_peak (latency_peak),
		.low_estimate (low_estimate),
		.high_estimate(high_estimate),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// The checker sees every channel, predicts each report and counts failures.
	log2_latency_histogram_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.channel        (channel),
		.sample         (sample),
		.done           (done),
		.sample_total   (sample_total),
		.latency_sum    (latency_sum),
		.latency_peak   (latency_peak),
		.low_estimate   (low_estimate),
		.high_estimate  (high_estimate),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.reports_pending(reports_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost report ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[log2_latency_histogram] ERROR");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Start is left
	// high on return so that a back-to-back request needs no new rising edge on it.
	task automatic issue_request(input logic f, input logic [CH_PORT_W-1:0] ch,
			input logic [SAMPLE_W-1:0] s);
		start   <= 1'b1;
		func    <= f;
		channel <= ch;
		sample  <= s;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start and idle the sender for a number of cycles.
	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every predicted report has come back, then let any
	// queued records finish before going on.
	task automatic drain_reports();
		pause_sender(1);
		while (reports_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both quantiles and then one spare index with junk, valid held high
	// across the three writes.
	task automatic set_quantiles(input logic [Q_W-1:0] lo, input logic [Q_W-1:0] hi);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [Q_W-1:0]       val [3];
		idx[0] = CFG_LOW_Q;
		val[0] = lo;
		idx[1] = CFG_HIGH_Q;
		val[1] = hi;
		idx[2] = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
		val[2] = Q_W'($urandom);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do
				@(posedge clk);
			while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Spread samples over every bucket: mostly a random word shifted down by a
	// random amount, with the edges of the range mixed in.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return SAMPLE_W'($urandom_range(0, 1));
		if (roll < 14)
			return $urandom_range(0, 1) ? '1 : {1'b1, {(SAMPLE_W-1){1'b0}}};
		return $urandom >> $urandom_range(0, SAMPLE_W - 1);
	endfunction

	initial begin
		logic [Q_W-1:0] lo_q [RANDOM_PHASES];
		logic [Q_W-1:0] hi_q [RANDOM_PHASES];
		bit             no_gaps;

		arst_n    = 1'b0;
		start     = 1'b0;
		func      = FUNC_RECORD;
		channel   = '0;
		sample    = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LOW_Q;
		cfg_data  = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// wait out the memory clearing sweep
		while (busy)
			@(posedge clk);

		// Directed: empty channels report all zero.
		issue_request(FUNC_REPORT, 2'd0, '1);
		issue_request(FUNC_REPORT, 2'd3, '0);
		// Edges of the sample range on channel 0, both ends of the low and top bucket boundaries.
		issue_request(FUNC_RECORD, 2'd0, 32'd0);
		issue_request(FUNC_RECORD, 2'd0, 32'd1);
		issue_request(FUNC_RECORD, 2'd0, 32'd2);
		issue_request(FUNC_RECORD, 2'd0, 32'd3);
		issue_request(FUNC_RECORD, 2'd0, 32'd4);
		issue_request(FUNC_RECORD, 2'd0, 32'h7FFF_FFFF);
		issue_request(FUNC_RECORD, 2'd0, 32'h8000_0000);
		issue_request(FUNC_RECORD, 2'd0, 32'hFFFF_FFFF);
		issue_request(FUNC_RECORD, 2'd0, 32'd1000);
		// Two full-scale samples carry the sum past 32 bits.
		issue_request(FUNC_RECORD, 2'd1, 32'hFFFF_FFFF);
		issue_request(FUNC_RECORD, 2'd1, 32'hFFFF_FFFF);
		issue_request(FUNC_RECORD, 2'd2, 32'd5);
		issue_request(FUNC_REPORT, 2'd0, '0);
		issue_request(FUNC_REPORT, 2'd1, '0);
		issue_request(FUNC_REPORT, 2'd2, '0);
		issue_request(FUNC_REPORT, 2'd3, '0);

		// Zero quantile gives the first bucket; full quantile the top occupied one.
		drain_reports();
		set_quantiles(10'd0, 10'd1000);
		issue_request(FUNC_REPORT, 2'd0, '0);
		issue_request(FUNC_REPORT, 2'd1, '0);

		// Quantile above 1000: the target overshoots the count and is never met.
		drain_reports();
		set_quantiles(10'd1023, 10'd1023);
		issue_request(FUNC_REPORT, 2'd0, '0);
		issue_request(FUNC_REPORT, 2'd2, '0);

		// Random phases, each under its own pair of quantiles.
		lo_q[0] = 10'd500;  hi_q[0] = 10'd990;
		lo_q[1] = 10'd1;    hi_q[1] = 10'd999;
		lo_q[2] = 10'd1000; hi_q[2] = 10'd0;
		lo_q[3] = 10'd1023; hi_q[3] = 10'd512;
		for (int p = 4; p < RANDOM_PHASES; p++) begin
			lo_q[p] = Q_W'($urandom);
			hi_q[p] = Q_W'($urandom_range(0, 1000));
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_reports();
			set_quantiles(lo_q[p], hi_q[p]);
			// one whole phase goes back to back with no sender gaps
			no_gaps = (p == 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// once, stop mid-phase until every report is back
				if (p == 1 && n == ITEMS_PER_PHASE / 2)
					drain_reports();
				else if (!no_gaps && $urandom_range(0, 99) < 34)
					pause_sender($urandom_range(1, 4));
				issue_request(($urandom_range(0, 4) == 0) ? FUNC_REPORT : FUNC_RECORD,
					CH_PORT_W'($urandom_range(0, 3)), pick_sample());
			end
		end

		drain_reports();
		if (fail_count == 0)
			$display("[log2_latency_histogram] OK");
		else
			$display("[log2_latency_histogram] ERROR");
		$finish;
	end

endmodule
